/* hw/rtl/bfiq_pkg.sv */
package bfiq_pkg;

    // store geometry
    localparam int FILTER_BITS_MAX = 65536;
    localparam int ADDR_W          = $clog2(FILTER_BITS_MAX);
    localparam int MOD_W           = $clog2(FILTER_BITS_MAX + 1);
    localparam int ROW_BITS        = 32;
    localparam int BIT_W           = $clog2(ROW_BITS);
    localparam int ROW_W           = ADDR_W - BIT_W;
    localparam int ROWS            = (FILTER_BITS_MAX + ROW_BITS - 1) / ROW_BITS;

    // field widths
    localparam int HASH_W  = 32;
    localparam int MODE_W  = 2;
    localparam int NP_W    = 8;
    localparam int FB_W    = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int FB_RESET   = 65536;

    // probe count limit
    localparam int PROBE_LIMIT = 30;
    localparam int PROBE_W     = $clog2(PROBE_LIMIT + 1);

    // rotate amount for the second hash
    localparam int ROT_AMT = 15;

    // divider lanes
    localparam int DIV_LANES = 3;
    localparam int LANE_H    = 0;
    localparam int LANE_D    = 1;
    localparam int LANE_F    = 2;
    localparam int DIV_CNT_W = $clog2(HASH_W);

    // command queue
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // input modes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROBES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BITS = 2'd1;

    localparam int CMP_W = (FB_W > MOD_W) ? FB_W : MOD_W;

    typedef enum logic [1:0] {
        CMD_INSERT,
        CMD_QUERY,
        CMD_PRESENT,
        CMD_CLEAR
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [PROBE_W-1:0]   probes;
        logic [HASH_W-1:0]    hash;
        logic [MOD_W-1:0]     modv;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_rd;

    typedef struct packed {
        logic init_busy;
    } t_bk_stat;

    typedef struct packed {
        logic                 start;
        logic [MOD_W-1:0]     modv;
        logic [DIV_LANES-1:0][HASH_W-1:0] num;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_LANES-1:0][MOD_W-1:0] rem;
    } t_div_rsp;

    function automatic logic [HASH_W-1:0] rot_hash(logic [HASH_W-1:0] h);
        return (h << ROT_AMT) | (h >> (HASH_W - ROT_AMT));
    endfunction

    // probe modulus, saturated at the store size
    function automatic logic [MOD_W-1:0] sat_mod(logic [FB_W-1:0] fb);
        logic [CMP_W-1:0] x;
        x = CMP_W'(fb);
        if (x > CMP_W'(FILTER_BITS_MAX)) begin
            return MOD_W'(FILTER_BITS_MAX);
        end
        return MOD_W'(x);
    endfunction

endpackage

/* hw/rtl/bfiq_if.sv */
interface bfiq_item_if;
    import bfiq_pkg::*;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [HASH_W-1:0]   hash_value;
    modport source (output valid, output mode, output hash_value, input ready);
    modport sink   (input valid, input mode, input hash_value, output ready);
endinterface

interface bfiq_res_if;
    logic valid;
    logic ready;
    logic maybe_present;
    modport source (output valid, output maybe_present, input ready);
    modport sink   (input valid, input maybe_present, output ready);
endinterface

interface bfiq_cfg_if;
    import bfiq_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/bfiq_front.sv */
module bfiq_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bfiq_item_if.sink         i_item,
    bfiq_cfg_if.sink          i_cfg,
    input  bfiq_pkg::t_bk_stat i_stat,
    input  logic              i_push_ready,
    output logic              o_push_valid,
    output bfiq_pkg::t_cmd    o_push_cmd
);
    import bfiq_pkg::*;

    logic [NP_W-1:0]    r_num_probes;
    logic [FB_W-1:0]    r_filter_bits;
    logic [MOD_W-1:0]   modv;
    logic [PROBE_W-1:0] k_ins;
    logic               np_big;
    logic               np_zero;
    logic               keep;
    t_cmd               cmd;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_probes  <= NP_W'(1);
            r_filter_bits <= FB_W'(FB_RESET);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_NUM_PROBES:  r_num_probes  <= i_cfg.data[NP_W-1:0];
                CFG_FILTER_BITS: r_filter_bits <= i_cfg.data[FB_W-1:0];
                default: ;
            endcase
        end
    end

    assign modv    = sat_mod(r_filter_bits);
    assign np_big  = (r_num_probes > NP_W'(PROBE_LIMIT));
    assign np_zero = (r_num_probes == '0);
    assign k_ins   = np_big ? PROBE_W'(PROBE_LIMIT) : r_num_probes[PROBE_W-1:0];

    // classify; empty inserts and unused modes are dropped here
    always_comb begin
        cmd.hash   = i_item.hash_value;
        cmd.modv   = modv;
        cmd.probes = k_ins;
        cmd.kind   = CMD_CLEAR;
        keep       = 1'b0;
        case (i_item.mode)
            MODE_INSERT: begin
                cmd.kind = CMD_INSERT;
                keep     = !np_zero && (modv != '0);
            end
            MODE_QUERY: begin
                keep = 1'b1;
                if (np_big || np_zero || (modv == '0)) begin
                    cmd.kind = CMD_PRESENT;
                end else begin
                    cmd.kind = CMD_QUERY;
                end
            end
            MODE_CLEAR: begin
                cmd.kind = CMD_CLEAR;
                keep     = 1'b1;
            end
            default: keep = 1'b0;
        endcase
    end

    assign i_item.ready = i_push_ready && !i_stat.init_busy;
    assign o_push_valid = i_item.valid && i_item.ready && keep;
    assign o_push_cmd   = cmd;

endmodule

/* hw/rtl/bfiq_queue.sv */
module bfiq_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  bfiq_pkg::t_cmd   i_push_cmd,
    output logic             o_push_ready,
    output bfiq_pkg::t_q_rd  o_rd,
    input  logic             i_pop
);
    import bfiq_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_rd.valid   = (r_cnt != '0);
    assign o_rd.cmd     = r_mem[r_rptr];
    assign push = i_push_valid && o_push_ready;
    assign pop  = i_pop && o_rd.valid;

    function automatic logic [QPTR_W-1:0] inc_ptr(logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= inc_ptr(r_wptr);
            end
            if (pop) begin
                r_rptr <= inc_ptr(r_rptr);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

endmodule

/* hw/rtl/bfiq_mod.sv */
module bfiq_mod (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfiq_pkg::t_div_req i_req,
    output bfiq_pkg::t_div_rsp o_rsp
);
    import bfiq_pkg::*;

    // restoring remainder, one dividend bit per cycle, three lanes in step
    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [MOD_W-1:0]     r_m;
    logic [DIV_LANES-1:0][HASH_W-1:0] r_num;
    logic [DIV_LANES-1:0][MOD_W-1:0]  r_rem;
    logic [DIV_LANES-1:0][MOD_W-1:0]  n_rem;

    always_comb begin
        for (int l = 0; l < DIV_LANES; l++) begin
            logic [MOD_W:0] t;
            t = {r_rem[l], r_num[l][HASH_W-1]};
            if (t >= {1'b0, r_m}) begin
                n_rem[l] = MOD_W'(t - {1'b0, r_m});
            end else begin
                n_rem[l] = MOD_W'(t);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(HASH_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_m   <= i_req.modv;
            r_num <= i_req.num;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            for (int l = 0; l < DIV_LANES; l++) begin
                r_num[l] <= r_num[l] << 1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

/* hw/rtl/bfiq_back.sv */
module bfiq_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfiq_pkg::t_q_rd    i_rd,
    output logic               o_pop,
    output bfiq_pkg::t_bk_stat o_stat,
    bfiq_res_if.source         o_result
);
    import bfiq_pkg::*;

    typedef enum logic [2:0] {
        S_INIT_CLR,
        S_IDLE,
        S_DIV,
        S_RD,
        S_CHK,
        S_CLR,
        S_RESP
    } t_state;

    t_state               r_state;
    t_kind                r_kind;
    logic [PROBE_W-1:0]   r_cnt;
    logic [ROW_W-1:0]     r_row;
    logic [HASH_W-1:0]    r_h;
    logic [HASH_W-1:0]    r_delta;
    logic                 r_carry;
    logic [MOD_W-1:0]     r_m;
    logic [MOD_W-1:0]     r_pos;
    logic [MOD_W-1:0]     r_dm;
    logic [MOD_W-1:0]     r_wm;
    logic [MOD_W-1:0]     r_tmp;
    logic                 r_ans;
    logic                 r_oval;
    logic                 r_oans;

    logic [ROW_BITS-1:0]  r_mem [ROWS];
    logic [ROW_BITS-1:0]  r_rdata;

    logic                 mem_we;
    logic [ROW_W-1:0]     mem_waddr;
    logic [ROW_BITS-1:0]  mem_wdata;
    logic [ROW_W-1:0]     mem_raddr;

    t_div_req             div_req;
    t_div_rsp             div_rsp;

    logic [MOD_W:0]       sum_a;
    logic [MOD_W-1:0]     tmp_a;
    logic [HASH_W:0]      hsum;
    logic [MOD_W-1:0]     fix_b;
    logic [MOD_W-1:0]     pos_next;
    logic [MOD_W:0]       f1;
    logic                 bit_set;
    logic                 out_free;
    logic                 oval_set;

    bfiq_mod u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_pop            = (r_state == S_IDLE) && i_rd.valid;
    assign o_stat.init_busy = (r_state == S_INIT_CLR);
    assign o_result.valid         = r_oval;
    assign o_result.maybe_present = r_oans;
    assign out_free = !r_oval || o_result.ready;
    assign oval_set = (r_state == S_RESP) && out_free;

    assign div_req.start       = o_pop && ((i_rd.cmd.kind == CMD_INSERT) ||
                                           (i_rd.cmd.kind == CMD_QUERY));
    assign div_req.modv        = i_rd.cmd.modv;
    assign div_req.num[LANE_H] = i_rd.cmd.hash;
    assign div_req.num[LANE_D] = rot_hash(i_rd.cmd.hash);
    assign div_req.num[LANE_F] = '1;

    // position of the next probe: add delta mod m now, fold in the 2^32 wrap next cycle
    assign sum_a = {1'b0, r_pos} + {1'b0, r_dm};
    assign tmp_a = (sum_a >= {1'b0, r_m}) ? MOD_W'(sum_a - {1'b0, r_m}) : MOD_W'(sum_a);
    assign hsum  = {1'b0, r_h} + {1'b0, r_delta};
    assign fix_b = (r_tmp >= r_wm) ? (r_tmp - r_wm)
                 : MOD_W'({1'b0, r_tmp} + {1'b0, r_m} - {1'b0, r_wm});
    assign pos_next = r_carry ? fix_b : r_tmp;
    assign f1       = {1'b0, div_rsp.rem[LANE_F]} + 1'b1;
    assign bit_set  = r_rdata[r_pos[BIT_W-1:0]];

    always_comb begin
        mem_raddr = r_pos[ADDR_W-1:BIT_W];
        mem_we    = 1'b0;
        mem_waddr = r_pos[ADDR_W-1:BIT_W];
        mem_wdata = r_rdata | (ROW_BITS'(1) << r_pos[BIT_W-1:0]);
        case (r_state)
            S_INIT_CLR, S_CLR: begin
                mem_we    = 1'b1;
                mem_waddr = r_row;
                mem_wdata = '0;
            end
            S_CHK: mem_we = (r_kind == CMD_INSERT);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT_CLR;
            r_row   <= '0;
            r_oval  <= 1'b0;
        end else begin
            if (oval_set) begin
                r_oval <= 1'b1;
            end else if (r_oval && o_result.ready) begin
                r_oval <= 1'b0;
            end
            case (r_state)
                S_INIT_CLR, S_CLR: begin
                    r_row <= r_row + 1'b1;
                    if (r_row == ROW_W'(ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_rd.valid) begin
                        r_kind <= i_rd.cmd.kind;
                        r_cnt  <= i_rd.cmd.probes;
                        r_m    <= i_rd.cmd.modv;
                        r_h    <= i_rd.cmd.hash;
                        r_delta <= rot_hash(i_rd.cmd.hash);
                        r_ans  <= 1'b1;
                        r_row  <= '0;
                        case (i_rd.cmd.kind)
                            CMD_CLEAR:   r_state <= S_CLR;
                            CMD_PRESENT: r_state <= S_RESP;
                            default:     r_state <= S_DIV;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_pos <= div_rsp.rem[LANE_H];
                        r_dm  <= div_rsp.rem[LANE_D];
                        r_wm  <= (f1 == {1'b0, r_m}) ? '0 : MOD_W'(f1);
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_tmp   <= tmp_a;
                    r_carry <= hsum[HASH_W];
                    r_h     <= hsum[HASH_W-1:0];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_pos <= pos_next;
                    r_cnt <= r_cnt - 1'b1;
                    if ((r_kind == CMD_QUERY) && !bit_set) begin
                        r_ans   <= 1'b0;
                        r_state <= S_RESP;
                    end else if (r_cnt == PROBE_W'(1)) begin
                        r_state <= (r_kind == CMD_QUERY) ? S_RESP : S_IDLE;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_oans  <= r_ans;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/bloom_filter_insert_query.sv */
// Channel   Dir  Handshake      Payload
// i_item    in   valid/ready    mode[1:0], hash_value[31:0]
// o_result  out  valid/ready    maybe_present
// i_cfg     in   valid/ready    index[1:0] (0 num_probes, 1 filter_bits), data[16:0]
//
// Insert/query: dequeue, then modulo (32 serial remainder steps, then done), then per probe
//   a row read, then a bit test/set, k <= 30; a query then posts its result.
// Clear: dequeue, then one 32-bit row per cycle, 2048 rows. No-probe query: dequeue, then post.
// Reset: synchronous, active low; then a clearing pass over every row, input ready low.
// A 2-entry command queue lets the front keep taking items while the back works or
//   the result register waits on o_result.ready; config writes are always taken.
module bloom_filter_insert_query (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bfiq_item_if.sink   i_item,
    bfiq_res_if.source  o_result,
    bfiq_cfg_if.sink    i_cfg
);
    import bfiq_pkg::*;

    // front -> queue
    logic     push_valid;
    logic     push_ready;
    t_cmd     push_cmd;
    // queue -> back
    t_q_rd    q_rd;
    logic     pop;
    // back status to front
    t_bk_stat bk_stat;

    // front: config registers, classification of each transaction
    bfiq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .i_cfg        (i_cfg),
        .i_stat       (bk_stat),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_cmd   (push_cmd)
    );

    // decoupling queue
    bfiq_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_cmd   (push_cmd),
        .o_push_ready (push_ready),
        .o_rd         (q_rd),
        .i_pop        (pop)
    );

    // back: modulo unit, probe sequencer, bit store, result register
    bfiq_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd     (q_rd),
        .o_pop    (pop),
        .o_stat   (bk_stat),
        .o_result (o_result)
    );

endmodule

/* hw/rtl/bfiq_checker.sv */
module bfiq_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_data,
    input logic i_cfg_valid,
    input logic i_cfg_ready
);

    // no result may be pending right after reset
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // clearing pass holds the input off after reset
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("input ready during clearing pass");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // config writes never stall
    a_cfg_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> i_cfg_ready)
        else $error("config write stalled");

endmodule

bind bloom_filter_insert_query bfiq_checker u_bfiq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.maybe_present),
    .i_cfg_valid (i_cfg.valid),
    .i_cfg_ready (i_cfg.ready)
);

/* bench/bloom_filter_insert_query_tb.sv */
module bloom_filter_insert_query_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfiq_pkg::*;

    // mode 3 has no meaning; the block must swallow it without a result
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 11;
    // worst case backlog when the block goes quiet: one clear running plus two
    // queued, and some slack
    localparam int SETTLE_CYCLES = 6400;
    localparam int REPORT_MAX    = 10;
    localparam int RANDOM_ITEMS  = 450;
    localparam int RANDOM_PHASES = 8;
    // clears walk every row of the store; keep the random part from spending its time there
    localparam int MAX_CLEARS    = 8;

    logic i_clk;
    logic i_rst_n;

    bfiq_item_if item_ch ();
    bfiq_res_if  res_ch ();
    bfiq_cfg_if  cfg_ch ();

    bloom_filter_insert_query dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (res_ch),
        .i_cfg    (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: bit store, register copies, pending answers
    // ------------------------------------------------------------------
    bit                shadow_bits [FILTER_BITS_MAX];
    logic [NP_W-1:0]   probe_count;
    logic [FB_W-1:0]   filter_size;
    bit                expected_answers [$];
    logic [HASH_W-1:0] inserted_keys [$];

    int mismatches;
    int burst_left;
    int clears_sent;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit: far above the slowest legal run (reset clearing pass, every
    // item at 30 probes, all clears, every settle pause, receiver stalls).
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Probe modulus; sizes above the store saturate at the store size.
    function automatic logic [HASH_W-1:0] probe_modulus();
        if (filter_size > FB_W'(FILTER_BITS_MAX)) begin
            return HASH_W'(FILTER_BITS_MAX);
        end
        return HASH_W'(filter_size);
    endfunction

    // Apply one accepted transaction to the shadow; queries queue an answer.
    function automatic void bloom_apply(input logic [MODE_W-1:0] mode,
                                        input logic [HASH_W-1:0] hash);
        logic [HASH_W-1:0] m;
        logic [HASH_W-1:0] step;
        logic [HASH_W-1:0] h;
        logic [HASH_W-1:0] pos;
        int                probes;
        bit                answer;
        m      = probe_modulus();
        // second hash: key rotated left by ROT_AMT
        step   = {hash[HASH_W-ROT_AMT-1:0], hash[HASH_W-1:HASH_W-ROT_AMT]};
        h      = hash;
        answer = 1'b1;
        case (mode)
            MODE_CLEAR: begin
                foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;
            end
            MODE_INSERT: begin
                // insert probes are capped; zero size or zero probes touch nothing
                probes = (probe_count > PROBE_LIMIT) ? PROBE_LIMIT : int'(probe_count);
                if (m != 0) begin
                    for (int i = 0; i < probes; i++) begin
                        pos = h % m;
                        shadow_bits[pos] = 1'b1;
                        h += step;
                    end
                end
            end
            MODE_QUERY: begin
                // above the cap, with zero size or zero probes: always present
                if (probe_count <= PROBE_LIMIT && m != 0) begin
                    for (int i = 0; i < int'(probe_count); i++) begin
                        pos = h % m;
                        if (!shadow_bits[pos]) begin
                            answer = 1'b0;
                            break;
                        end
                        h += step;
                    end
                end
                expected_answers = {expected_answers, answer};
            end
            default: ;
        endcase
    endfunction

    // Key source: mostly uniform, sometimes all-zero, all-one, one-hot or one-cold keys.
    function automatic logic [HASH_W-1:0] random_key();
        logic [HASH_W-1:0] one_hot;
        one_hot = HASH_W'(1) << $urandom_range(0, HASH_W - 1);
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return one_hot;
            3:       return ~one_hot;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Item sender: one transaction per call, bursts with random gaps
    // ------------------------------------------------------------------
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [HASH_W-1:0] hash);
        int gap;
        item_ch.valid      <= 1'b1;
        item_ch.mode       <= mode;
        item_ch.hash_value <= hash;
        do @(posedge i_clk); while (!item_ch.ready);
        // transaction taken at this edge
        bloom_apply(mode, hash);
        if (mode == MODE_INSERT) inserted_keys = {inserted_keys, hash};
        if (mode == MODE_CLEAR) inserted_keys.delete();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 6);
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            // now and then a long burst with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic wait_answers();
        while (expected_answers.size() != 0) @(posedge i_clk);
    endtask

    // Idle the block: no answer pending, then let inserts/clears still queued
    // inside finish (they produce nothing we could wait on).
    task automatic quiesce();
        item_ch.valid <= 1'b0;
        wait_answers();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (index)
            CFG_NUM_PROBES:  probe_count = data[NP_W-1:0];
            CFG_FILTER_BITS: filter_size = data[FB_W-1:0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [NP_W-1:0] probes, input logic [FB_W-1:0] size);
        quiesce();
        write_reg(CFG_NUM_PROBES, CFG_DATA_W'(probes));
        write_reg(CFG_FILTER_BITS, CFG_DATA_W'(size));
    endtask

    // ------------------------------------------------------------------
    // Result receiver: ready pattern switches between always-on, coin-flip
    // and long-stall styles for random stretches
    // ------------------------------------------------------------------
    initial begin
        int style;
        int left;
        style = 0;
        left  = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                style = $urandom_range(0, 2);
                left  = $urandom_range(20, 200);
            end else begin
                left--;
            end
            case (style)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= 1'($urandom_range(0, 1));
                default: res_ch.ready <= ($urandom_range(0, 11) == 0);
            endcase
        end
    end

    // Result checker: every taken result against the oldest pending answer.
    always @(posedge i_clk) begin : check_answers
        bit want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_answers.size() == 0) begin
                if (mismatches < REPORT_MAX) begin
                    $display("%0t: result with none pending: maybe_present=%0b",
                             $realtime, res_ch.maybe_present);
                end
                mismatches++;
            end else begin
                want = expected_answers.pop_front();
                if (res_ch.maybe_present !== want) begin
                    if (mismatches < REPORT_MAX) begin
                        $display("%0t: maybe_present mismatch: expected %0b, got %0b",
                                 $realtime, want, res_ch.maybe_present);
                    end
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset registers (1 probe, full store): extreme keys and the unused mode.
    task automatic test_defaults();
        send_item(MODE_QUERY,  32'h0000_0000);     // empty store: absent
        send_item(MODE_INSERT, 32'h0000_0000);
        send_item(MODE_QUERY,  32'h0000_0000);
        send_item(MODE_INSERT, 32'hFFFF_FFFF);
        send_item(MODE_UNUSED, 32'hFFFF_FFFF);     // ignored, no result
        send_item(MODE_QUERY,  32'hFFFF_FFFF);
    endtask

    // Probe count: zero, the cap, just above it and the register maximum.
    task automatic test_probe_limits();
        set_config(8'd0, 17'd999);
        send_item(MODE_INSERT, 32'h1234_5678);     // no probes: store untouched
        send_item(MODE_QUERY,  32'h1234_5678);     // no probes: present
        set_config(8'd30, 17'd999);
        send_item(MODE_QUERY,  32'h1234_5678);     // proves the insert above did nothing
        set_config(8'd255, 17'd999);
        send_item(MODE_INSERT, 32'h8765_4321);     // insert capped at 30 probes
        send_item(MODE_QUERY,  32'hDEAD_BEEF);     // over the cap: present without lookup
        set_config(8'd31, 17'd999);
        send_item(MODE_QUERY,  32'hC0FF_EE00);
        set_config(8'd30, 17'd999);
        send_item(MODE_QUERY,  32'h8765_4321);     // all 30 capped probes were set
    endtask

    // Store size: empty, saturating, tiny and not a multiple of 8.
    task automatic test_filter_sizes();
        set_config(8'd4, 17'd0);
        send_item(MODE_INSERT, 32'hA5A5_0001);     // empty filter: no write
        send_item(MODE_QUERY,  32'hA5A5_0001);     // empty filter: present
        set_config(8'd4, 17'h1FFFF);               // saturates to the store size
        send_item(MODE_INSERT, 32'h3C3C_7E7E);
        send_item(MODE_QUERY,  32'h3C3C_7E7E);
        set_config(8'd4, 17'd65537);               // same saturated modulus
        send_item(MODE_QUERY,  32'h3C3C_7E7E);
        set_config(8'd2, 17'd1);
        send_item(MODE_INSERT, 32'h0000_F00D);
        send_item(MODE_QUERY,  32'h0000_F00D);
        set_config(8'd3, 17'd67);
        send_item(MODE_INSERT, 32'hFFFF_FFFF);
        send_item(MODE_QUERY,  32'hFFFF_FFFF);
    endtask

    task automatic test_clear();
        send_item(MODE_INSERT, 32'h0BAD_F00D);
        send_item(MODE_QUERY,  32'h0BAD_F00D);
        send_item(MODE_CLEAR,  32'h5555_AAAA);
        send_item(MODE_QUERY,  32'h0BAD_F00D);     // store wiped: absent
    endtask

    // Random phases, each under its own register setting. Small stores with few
    // probes dominate so answers split between present and absent; about a third
    // of the traffic re-queries keys already inserted.
    task automatic test_random();
        int                counted;
        int                pick;
        logic [NP_W-1:0]   probes;
        logic [FB_W-1:0]   size;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 9))
                0:       probes = NP_W'($urandom_range(31, 255));
                1:       probes = '0;
                2:       probes = NP_W'($urandom_range(20, 30));
                default: probes = NP_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 9))
                0:       size = FB_W'($urandom_range(65536, 131071));
                1:       size = FB_W'($urandom_range(2048, 65535));
                2:       size = FB_W'($urandom_range(1, 63));
                default: size = FB_W'($urandom_range(64, 1023));
            endcase
            set_config(probes, size);
            counted = 0;
            while (counted < RANDOM_ITEMS / RANDOM_PHASES) begin
                // once mid-stream, hold off until every pending answer is back
                if (phase == 1 && counted == 30) begin
                    item_ch.valid <= 1'b0;
                    wait_answers();
                    @(posedge i_clk);
                end
                pick = $urandom_range(0, 99);
                if (pick < 38) begin
                    send_item(MODE_INSERT, random_key());
                end else if (pick < 70 && inserted_keys.size() != 0) begin
                    send_item(MODE_QUERY,
                              inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
                end else if (pick < 96) begin
                    send_item(MODE_QUERY, random_key());
                end else if (pick < 98) begin
                    send_item(MODE_UNUSED, random_key());
                    continue;                          // ignored: does not count
                end else if (clears_sent < MAX_CLEARS) begin
                    send_item(MODE_CLEAR, random_key());
                    clears_sent++;
                end else begin
                    send_item(MODE_QUERY, random_key());
                end
                counted++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n            <= 1'b0;
        item_ch.valid      <= 1'b0;
        item_ch.mode       <= MODE_INSERT;
        item_ch.hash_value <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_NUM_PROBES;
        cfg_ch.data        <= '0;
        mismatches  = 0;
        burst_left  = 0;
        clears_sent = 0;
        foreach (shadow_bits[i]) shadow_bits[i] = 1'b0;
        probe_count = NP_W'(1);
        filter_size = FB_W'(FB_RESET);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // item ready stays low through the clearing pass; send_item waits on it

        test_defaults();
        test_probe_limits();
        test_filter_sizes();
        test_clear();
        test_random();

        quiesce();
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
